### sv/brp_pkg.sv
// Shared constants, types and result codes of the buffer recycle pool.
`default_nettype none
package brp_pkg;

	localparam int POOL_ENTRIES  = 32;
	localparam int HANDLE_BITS   = 16;
	localparam int SIZE_BITS     = 32;
	localparam int BUDGET_BITS   = 36;
	localparam int TOTAL_BITS    = 37;
	localparam int CNT_BITS      = $clog2(POOL_ENTRIES + 1);
	localparam int IN_DATA_BITS  = ((SIZE_BITS + HANDLE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((HANDLE_BITS + 7) / 8) * 8;

	localparam logic [BUDGET_BITS-1:0] BUDGET_RESET = BUDGET_BITS'(64'd1073741824);

	typedef enum logic [1:0] {
		KIND_EVICT = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_HIT   = 2'd2,
		KIND_MISS  = 2'd3
	} kind_t;

	typedef enum logic {
		ACT_STORE = 1'b0,
		ACT_FETCH = 1'b1
	} action_t;

	// One pool record: byte size and buffer handle
	typedef struct packed {
		logic [SIZE_BITS-1:0]   bytes;
		logic [HANDLE_BITS-1:0] handle;
	} rec_t;

	// Per-cell controls: take neighbor record, or take broadcast record
	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

	// Station controls: start a new pass, process the head record
	typedef struct packed {
		logic clear;
		logic step;
	} stn_ctrl_t;

endpackage
`default_nettype wire

### sv/buffer_recycle_pool_unit.sv
// Top level of the buffer recycle pool: record chain, station, sequencer and ports.
`default_nettype none
// Records sit in a chain of cells in age order, oldest in cell 0. Removing a size
// rotates the live records once through the head station, one cell per cycle; a
// fetch makes one such pass, and a store one pass for each eviction. One item is
// worked at a time; the input is taken again once its last result is in the output
// register. s_axis_tuser is the action, m_axis_tuser the result kind.
module buffer_recycle_pool_unit import brp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,  // buffer_size, buffer_handle
	input  logic                     s_axis_tuser,  // action
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [OUT_DATA_BITS-1:0] m_axis_tdata,  // handle_out
	output logic [1:0]               m_axis_tuser,  // kind
	output logic                     m_axis_tlast,
	input  logic                     cfg_we,
	input  logic [BUDGET_BITS-1:0]   cfg_wdata
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_CHECK  = 5'b00010,
		S_PASS   = 5'b00100,
		S_INSERT = 5'b01000,
		S_EMIT   = 5'b10000
	} state_t;

	state_t                  state_q;
	action_t                 act_q;
	logic [SIZE_BITS-1:0]    size_q;
	logic [HANDLE_BITS-1:0]  handle_q;
	logic [SIZE_BITS-1:0]    key_q;
	logic [CNT_BITS-1:0]     steps_q;
	logic [CNT_BITS-1:0]     cnt_q;
	logic [TOTAL_BITS-1:0]   total_q;
	logic [BUDGET_BITS-1:0]  budget_q;
	kind_t                   pend_kind_q;
	logic [HANDLE_BITS-1:0]  pend_handle_q;
	logic                    pend_last_q;
	logic                    m_valid_q;
	kind_t                   m_kind_q;
	logic [HANDLE_BITS-1:0]  m_handle_q;
	logic                    m_last_q;

	rec_t                    rec [POOL_ENTRIES];
	cell_ctrl_t              cctl [POOL_ENTRIES];
	rec_t                    bus;
	rec_t                    tail;
	logic                    drop;
	logic                    found;
	logic [HANDLE_BITS-1:0]  carry;
	stn_ctrl_t               sctl;
	logic                    in_acc;
	logic                    pass_step;
	logic                    over_budget;
	logic                    evict_go;
	logic                    emit_go;

	// Handshake and pass decisions
	always_comb begin
		s_axis_tready = (state_q == S_IDLE);
		in_acc        = s_axis_tvalid && s_axis_tready;
		pass_step     = (state_q == S_PASS) && (steps_q != '0);
		over_budget   = ({1'b0, total_q} + (TOTAL_BITS + 1)'(size_q))
			> (TOTAL_BITS + 1)'(budget_q);
		evict_go      = (cnt_q != '0)
			&& (over_budget || (cnt_q == CNT_BITS'(POOL_ENTRIES)));
		emit_go       = (state_q == S_EMIT) && (!m_valid_q || m_axis_tready);
		sctl.clear    = in_acc || ((state_q == S_CHECK) && evict_go);
		sctl.step     = pass_step;
		bus           = (state_q == S_INSERT) ? rec_t'({size_q, handle_q}) : tail;
	end

	// Chain of record cells
	for (genvar i = 0; i < POOL_ENTRIES; i++) begin : g_cell
		rec_t nbr;
		if (i < POOL_ENTRIES - 1) begin : g_mid
			assign nbr = rec[i+1];
		end else begin : g_end
			assign nbr = rec[i];
		end
		assign cctl[i].shift = pass_step && (CNT_BITS'(i + 1) < cnt_q);
		assign cctl[i].load  = (pass_step && !drop && (CNT_BITS'(i + 1) == cnt_q))
			|| ((state_q == S_INSERT) && (CNT_BITS'(i) == cnt_q));
		brp_cell u_cell (
			.clk   (clk),
			.ctrl  (cctl[i]),
			.nbr   (nbr),
			.bus   (bus),
			.rec_q (rec[i])
		);
	end

	brp_station u_station (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (sctl),
		.key     (key_q),
		.head    (rec[0]),
		.tail    (tail),
		.drop    (drop),
		.found_q (found),
		.carry_q (carry)
	);

	// Sequence store, eviction and fetch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			total_q  <= '0;
			steps_q  <= '0;
			budget_q <= BUDGET_RESET;
		end else begin
			if (cfg_we) begin
				budget_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (action_t'(s_axis_tuser) == ACT_FETCH) begin
							steps_q <= cnt_q;
							state_q <= S_PASS;
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (evict_go) begin
						steps_q <= cnt_q;
						state_q <= S_PASS;
					end else begin
						state_q <= S_INSERT;
					end
				end
				S_PASS: begin
					if (steps_q != '0) begin
						steps_q <= steps_q - 1'b1;
						if (drop) begin
							cnt_q   <= cnt_q - 1'b1;
							total_q <= total_q - TOTAL_BITS'(key_q);
						end
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_INSERT: begin
					cnt_q   <= cnt_q + 1'b1;
					total_q <= total_q + TOTAL_BITS'(size_q);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						state_q <= pend_last_q ? S_IDLE : S_CHECK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Latch item fields, pass key and pending result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q    <= action_t'(s_axis_tuser);
			size_q   <= s_axis_tdata[SIZE_BITS-1:0];
			handle_q <= s_axis_tdata[SIZE_BITS +: HANDLE_BITS];
			key_q    <= s_axis_tdata[SIZE_BITS-1:0];
		end else if ((state_q == S_CHECK) && evict_go) begin
			key_q <= rec[0].bytes;
		end
		if ((state_q == S_PASS) && (steps_q == '0)) begin
			if (act_q == ACT_STORE) begin
				pend_kind_q   <= KIND_EVICT;
				pend_handle_q <= carry;
				pend_last_q   <= 1'b0;
			end else begin
				pend_kind_q   <= found ? KIND_HIT : KIND_MISS;
				pend_handle_q <= found ? carry : '0;
				pend_last_q   <= 1'b1;
			end
		end else if (state_q == S_INSERT) begin
			pend_kind_q   <= KIND_DONE;
			pend_handle_q <= '0;
			pend_last_q   <= 1'b1;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit_go) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (emit_go) begin
			m_kind_q   <= pend_kind_q;
			m_handle_q <= pend_handle_q;
			m_last_q   <= pend_last_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_DATA_BITS'(m_handle_q);
	assign m_axis_tuser  = m_kind_q;
	assign m_axis_tlast  = m_last_q;

endmodule
`default_nettype wire

### sv/brp_cell.sv
// One pool cell: holds a record, shifts from its younger neighbor or loads the bus.
`default_nettype none
module brp_cell import brp_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  rec_t       nbr,
	input  rec_t       bus,
	output rec_t       rec_q
);

	// Advance toward the head, or load the tail or append record
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			rec_q <= nbr;
		end else if (ctrl.load) begin
			rec_q <= bus;
		end
	end

endmodule
`default_nettype wire

### sv/brp_station.sv
// Head station: matches the popped record, drops the first match, rotates handles.
`default_nettype none
module brp_station import brp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  stn_ctrl_t              ctrl,
	input  logic [SIZE_BITS-1:0]   key,
	input  rec_t                   head,
	output rec_t                   tail,
	output logic                   drop,
	output logic                   found_q,
	output logic [HANDLE_BITS-1:0] carry_q
);

	logic match;

	// Drop the oldest match, hand older handles to younger matches
	always_comb begin
		match       = (head.bytes == key);
		drop        = match && !found_q;
		tail.bytes  = head.bytes;
		tail.handle = match ? carry_q : head.handle;
	end

	// Track first match of the pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.clear) begin
			found_q <= 1'b0;
		end else if (ctrl.step && match) begin
			found_q <= 1'b1;
		end
	end

	// Hold the handle pushed out by the last match
	always_ff @(posedge clk) begin
		if (ctrl.step && match) begin
			carry_q <= head.handle;
		end
	end

endmodule
`default_nettype wire

### sv/brp_checker.sv
// Port checker for the buffer recycle pool, bound to the top level.
`default_nettype none
module brp_checker import brp_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     m_axis_tvalid,
	input logic                     m_axis_tready,
	input logic [OUT_DATA_BITS-1:0] m_axis_tdata,
	input logic [1:0]               m_axis_tuser,
	input logic                     m_axis_tlast
);

	// Stalled result keeps valid
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result valid dropped while stalled");

	// Stalled result keeps its payload
	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result payload changed while stalled");

	// Only evictions continue a transaction's results
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != KIND_EVICT)))
		else $error("tlast does not match result kind");

	// Store done and fetch miss carry no handle
	a_zero_handle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_DONE || m_axis_tuser == KIND_MISS)
		|-> (m_axis_tdata == '0))
		else $error("handle on a result that carries none");

endmodule

bind buffer_recycle_pool_unit brp_checker u_brp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
